### hdl/dnmrn_pkg.sv
// Shared constants and types of the direct NM ring node.
`timescale 1ns / 1ps

package dnmrn_pkg;

    localparam int NODE_SLOTS_DEF = 32;

    localparam int ID_W = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int MAX_FRAMES = 3;

    // Input function codes.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_MSG   = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // Opcode bits and message types.
    localparam logic [7:0] OPC_ALIVE      = 8'h01;
    localparam logic [7:0] OPC_RING       = 8'h02;
    localparam logic [7:0] OPC_LIMP_HOME  = 8'h04;
    localparam logic [7:0] OPC_SLEEP_IND  = 8'h10;
    localparam logic [7:0] OPC_SLEEP_ACK  = 8'h20;
    localparam logic [7:0] MSGTYPE_MASK   = 8'h07;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPICAL_TICKS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TICKS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ID_MIN        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ID_MAX        = 3'd4;

    // Signals handed from one list cell to the next.
    typedef struct packed {
        logic            tok;
        logic            found;
        logic            valid;
        logic            keep;
        logic [ID_W-1:0] entry;
    } link_t;

endpackage

### hdl/dnmrn_if.sv
// Handshake channel interfaces for the input events and the results.
`timescale 1ns / 1ps

interface dnmrn_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] src_id;
    logic [7:0] dest_id;
    logic [7:0] opcode;

    modport source (output valid, func, src_id, dest_id, opcode, input ready);
    modport sink (input valid, func, src_id, dest_id, opcode, output ready);
endinterface

interface dnmrn_out_if;
    logic       valid;
    logic       ready;
    logic       has_frame;
    logic [7:0] frame_dest;
    logic [7:0] frame_opcode;
    logic       last;
    logic       ring_is_stable;
    logic       sleep_indicated;
    logic       prepare_sleep;

    modport source (output valid, has_frame, frame_dest, frame_opcode, last,
                    ring_is_stable, sleep_indicated, prepare_sleep, input ready);
    modport sink (input valid, has_frame, frame_dest, frame_opcode, last,
                  ring_is_stable, sleep_indicated, prepare_sleep, output ready);
endinterface

### hdl/dnmrn_cell.sv
// One slot of the sorted node list with its share of the presence scan.
`timescale 1ns / 1ps

module dnmrn_cell
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ins,
    input  logic [dnmrn_pkg::ID_W-1:0] id,
    input  dnmrn_pkg::link_t         prev,
    output dnmrn_pkg::link_t         nxt
);

    logic [dnmrn_pkg::ID_W-1:0] entry_reg;
    logic                       valid_reg;
    logic                       tok_reg;
    logic                       found_reg;
    logic                       match;
    logic                       keep;

    assign match = valid_reg && (entry_reg == id);
    assign keep  = valid_reg && (entry_reg < id);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            tok_reg   <= prev.tok;
            found_reg <= prev.found | match;
            if (ins)
            begin
                valid_reg <= valid_reg | prev.valid;
            end
        end
    end

    // Entries at or above the new id move one slot up.
    always_ff @(posedge clk)
    begin
        if (ins && !keep)
        begin
            entry_reg <= prev.keep ? id : prev.entry;
        end
    end

    assign nxt.tok   = tok_reg;
    assign nxt.found = found_reg;
    assign nxt.valid = valid_reg;
    assign nxt.keep  = keep;
    assign nxt.entry = entry_reg;

endmodule

### hdl/direct_nm_ring_node_unit.sv
// Top level of the direct NM ring node: event sequencer, timers and list chain.
`timescale 1ns / 1ps

// One node of a direct network-management logical ring. Each input transfer is
// a tick, a received NM message, a start request or the spare code; it yields
// one to three result transfers, the frames to send in order or a single
// status-only result, each carrying the ring-stable, sleep and pre-sleep flags
// after the event. The node id list is a chain of NODE_SLOTS cells; whenever an
// event inserts an id, a presence token walks the chain one cell per cycle and
// the insert is made in the cycle it leaves the last cell. An event that inserts
// an id thus lasts at least as long as the chain walk; receiver stalls lengthen
// every event. A new event is taken only once all results of the previous one
// are delivered and its insert is complete.
module direct_nm_ring_node_unit
#(
    parameter int NODE_SLOTS = dnmrn_pkg::NODE_SLOTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dnmrn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dnmrn_pkg::CFG_DATA_W-1:0]  cfg_data,
    dnmrn_in_if.sink                          in_ch,
    dnmrn_out_if.source                       out_ch
);

    localparam int CNT_W = $clog2(NODE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(NODE_SLOTS);

    typedef enum logic {ST_IDLE, ST_BUSY} state_t;

    state_t state_reg;

    // Configuration registers.
    logic [7:0] own_reg, tt_reg, mt_reg, mins_reg, maxs_reg;

    // Ring state.
    logic [7:0] pred_reg, succ_reg, tc_reg, mc_reg;
    logic       st_reg, sl_reg, ap_reg, ta_reg, ma_reg, ps_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0] first_reg, last_reg;

    // Result buffer of the event in progress.
    logic [7:0] fd_reg [dnmrn_pkg::MAX_FRAMES];
    logic [7:0] fo_reg [dnmrn_pkg::MAX_FRAMES];
    logic [1:0] nfr_reg;
    logic [1:0] k_reg;
    logic       out_done_reg;

    // List scan control.
    logic       scan_start_reg;
    logic       scan_busy_reg;
    logic [7:0] ins_id_reg;

    // Combinational outcome of one event.
    logic [7:0] pred_next, succ_next, tc_next, mc_next;
    logic       st_next, sl_next, ap_next, ta_next, ma_next, ps_next;
    logic [7:0] fd_next [dnmrn_pkg::MAX_FRAMES];
    logic [7:0] fo_next [dnmrn_pkg::MAX_FRAMES];
    logic [1:0] nfr_next;
    logic       ins_req_next;
    logic [7:0] ins_id_next;

    dnmrn_pkg::link_t links [NODE_SLOTS+1];
    logic ins_pulse;
    logic in_fire, out_fire;
    logic [1:0] nres;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;

    // The event step. Ring reset is flagged where it occurs and applied after the case;
    // its list insert of the own id is always the last thing an event does.
    always_comb
    begin
        logic [7:0] src, dst, op, me;
        logic       ring_rst;
        src = in_ch.src_id;
        dst = in_ch.dest_id;
        op  = in_ch.opcode;
        me  = own_reg;
        ring_rst = 1'b0;

        pred_next = pred_reg;
        succ_next = succ_reg;
        tc_next   = tc_reg;
        mc_next   = mc_reg;
        st_next   = st_reg;
        sl_next   = sl_reg;
        ap_next   = ap_reg;
        ta_next   = ta_reg;
        ma_next   = ma_reg;
        ps_next   = ps_reg;
        nfr_next  = 2'd0;
        ins_req_next = 1'b0;
        ins_id_next  = src;
        for (int i = 0; i < dnmrn_pkg::MAX_FRAMES; i++)
        begin
            fd_next[i] = 8'd0;
            fo_next[i] = 8'd0;
        end

        unique case (in_ch.func)
            dnmrn_pkg::FUNC_TICK:
            begin
                if (ap_reg)
                begin
                    fd_next[0] = me;
                    fo_next[0] = dnmrn_pkg::OPC_ALIVE;
                    nfr_next   = 2'd1;
                end
                else
                begin
                    if (ta_reg)
                    begin
                        tc_next = tc_reg + 8'd1;
                        if (tc_next == tt_reg)
                        begin
                            ta_next = 1'b0;
                            tc_next = 8'd0;
                            if (!st_reg)
                            begin
                                if (count_reg != '0)
                                begin
                                    if (pred_reg == mins_reg) pred_next = last_reg;
                                    if (succ_reg == maxs_reg) succ_next = first_reg;
                                end
                                st_next = 1'b1;
                                if (count_reg != '0 && first_reg == me)
                                begin
                                    fd_next[0] = succ_next;
                                    fo_next[0] = dnmrn_pkg::OPC_RING;
                                    nfr_next   = 2'd1;
                                end
                            end
                            fd_next[nfr_next] = pred_next;
                            fo_next[nfr_next] = sl_reg ?
                                (dnmrn_pkg::OPC_RING | dnmrn_pkg::OPC_SLEEP_IND) :
                                dnmrn_pkg::OPC_RING;
                            nfr_next = nfr_next + 2'd1;
                            ma_next  = 1'b1;
                            mc_next  = 8'd0;
                        end
                    end
                    if (ma_next)
                    begin
                        mc_next = mc_next + 8'd1;
                        if (mc_next == mt_reg)
                        begin
                            ma_next  = 1'b0;
                            mc_next  = 8'd0;
                            ring_rst = 1'b1;
                        end
                    end
                end
            end
            dnmrn_pkg::FUNC_MSG:
            begin
                ap_next = 1'b0;
                ta_next = 1'b0;
                tc_next = 8'd0;
                ma_next = 1'b0;
                mc_next = 8'd0;
                if ((op & dnmrn_pkg::MSGTYPE_MASK) == dnmrn_pkg::OPC_ALIVE)
                begin
                    if (dst > pred_reg && dst < me) pred_next = src;
                    if (src > me && src < succ_reg) succ_next = src;
                    ins_req_next = 1'b1;
                    ins_id_next  = src;
                    st_next      = 1'b0;
                end
                else if ((op & dnmrn_pkg::MSGTYPE_MASK) == dnmrn_pkg::OPC_RING)
                begin
                    if ((dst > me && src < me) || (dst < src && src < me) ||
                        (dst < src && dst > me))
                    begin
                        ring_rst = 1'b1;
                    end
                    else if (dst == me)
                    begin
                        pred_next = src;
                        if ((op & dnmrn_pkg::OPC_SLEEP_IND) != 8'd0)
                        begin
                            sl_next = 1'b1;
                            ps_next = 1'b1;
                        end
                        ta_next = 1'b1;
                        tc_next = 8'd0;
                    end
                    else
                    begin
                        ma_next = 1'b1;
                        mc_next = 8'd0;
                    end
                end
            end
            dnmrn_pkg::FUNC_START:
            begin
                ps_next  = 1'b0;
                ring_rst = 1'b1;
            end
            default:
            begin
                ring_rst = 1'b0;
            end
        endcase

        if (ring_rst)
        begin
            st_next   = 1'b0;
            sl_next   = 1'b0;
            ap_next   = 1'b1;
            succ_next = maxs_reg;
            pred_next = mins_reg;
            fd_next[nfr_next] = me;
            fo_next[nfr_next] = dnmrn_pkg::OPC_ALIVE;
            nfr_next  = nfr_next + 2'd1;
            ta_next   = 1'b1;
            tc_next   = 8'd0;
            ins_req_next = 1'b1;
            ins_id_next  = me;
        end
    end

    // The node list chain.
    assign links[0].tok   = scan_start_reg;
    assign links[0].found = 1'b0;
    assign links[0].valid = 1'b1;
    assign links[0].keep  = 1'b1;
    assign links[0].entry = ins_id_reg;

    assign ins_pulse = links[NODE_SLOTS].tok && !links[NODE_SLOTS].found;

    for (genvar g = 0; g < NODE_SLOTS; g++)
    begin : g_cell
        dnmrn_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ins   (ins_pulse),
            .id    (ins_id_reg),
            .prev  (links[g]),
            .nxt   (links[g+1])
        );
    end

    // Sequencer, configuration and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            own_reg        <= 8'd1;
            tt_reg         <= 8'd10;
            mt_reg         <= 8'd26;
            mins_reg       <= 8'd0;
            maxs_reg       <= 8'd255;
            pred_reg       <= 8'd0;
            succ_reg       <= 8'd255;
            tc_reg         <= 8'd0;
            mc_reg         <= 8'd0;
            st_reg         <= 1'b0;
            sl_reg         <= 1'b0;
            ap_reg         <= 1'b1;
            ta_reg         <= 1'b0;
            ma_reg         <= 1'b0;
            ps_reg         <= 1'b0;
            count_reg      <= '0;
            nfr_reg        <= 2'd0;
            k_reg          <= 2'd0;
            out_done_reg   <= 1'b1;
            scan_start_reg <= 1'b0;
            scan_busy_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dnmrn_pkg::REG_OWN_ADDRESS:   own_reg  <= cfg_data;
                    dnmrn_pkg::REG_TYPICAL_TICKS: tt_reg   <= cfg_data;
                    dnmrn_pkg::REG_MAX_TICKS:     mt_reg   <= cfg_data;
                    dnmrn_pkg::REG_ID_MIN:        mins_reg <= cfg_data;
                    dnmrn_pkg::REG_ID_MAX:        maxs_reg <= cfg_data;
                    default:                      own_reg  <= own_reg;
                endcase
            end

            scan_start_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        pred_reg     <= pred_next;
                        succ_reg     <= succ_next;
                        tc_reg       <= tc_next;
                        mc_reg       <= mc_next;
                        st_reg       <= st_next;
                        sl_reg       <= sl_next;
                        ap_reg       <= ap_next;
                        ta_reg       <= ta_next;
                        ma_reg       <= ma_next;
                        ps_reg       <= ps_next;
                        nfr_reg      <= nfr_next;
                        k_reg        <= 2'd0;
                        out_done_reg <= 1'b0;
                        // An insert into a full list is dropped without a scan.
                        if (ins_req_next && count_reg < SLOTS_C)
                        begin
                            scan_start_reg <= 1'b1;
                            scan_busy_reg  <= 1'b1;
                        end
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY:
                begin
                    if (out_fire)
                    begin
                        if (out_ch.last)
                        begin
                            out_done_reg <= 1'b1;
                        end
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end
                    if (links[NODE_SLOTS].tok)
                    begin
                        scan_busy_reg <= 1'b0;
                    end
                    if (ins_pulse)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if ((out_done_reg || (out_fire && out_ch.last)) &&
                        (!scan_busy_reg || links[NODE_SLOTS].tok))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ins_id_reg <= ins_id_next;
            for (int i = 0; i < dnmrn_pkg::MAX_FRAMES; i++)
            begin
                fd_reg[i] <= fd_next[i];
                fo_reg[i] <= fo_next[i];
            end
        end
        // The smallest and largest ids give the list's first and last entries.
        if (ins_pulse)
        begin
            if (count_reg == '0)
            begin
                first_reg <= ins_id_reg;
                last_reg  <= ins_id_reg;
            end
            else
            begin
                if (ins_id_reg < first_reg) first_reg <= ins_id_reg;
                if (ins_id_reg > last_reg)  last_reg  <= ins_id_reg;
            end
        end
    end

    assign nres = (nfr_reg == 2'd0) ? 2'd1 : nfr_reg;

    assign in_ch.ready            = (state_reg == ST_IDLE);
    assign out_ch.valid           = (state_reg == ST_BUSY) && !out_done_reg;
    assign out_ch.has_frame       = (k_reg < nfr_reg);
    assign out_ch.frame_dest      = (k_reg < nfr_reg) ? fd_reg[k_reg] : 8'd0;
    assign out_ch.frame_opcode    = (k_reg < nfr_reg) ? fo_reg[k_reg] : 8'd0;
    assign out_ch.last            = (k_reg == nres - 2'd1);
    assign out_ch.ring_is_stable  = st_reg;
    assign out_ch.sleep_indicated = sl_reg;
    assign out_ch.prepare_sleep   = ps_reg;

    // A new event is never taken while an insert is still walking the chain.
    a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !scan_busy_reg)
        else $error("input taken while list scan busy");

    // The list never holds more ids than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_C)
        else $error("node count above slot count");

    // An insert only happens while a scan is running.
    a_insert_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ins_pulse |-> scan_busy_reg)
        else $error("list insert outside a scan");

endmodule

### sim/direct_nm_ring_node_unit_checker.sv
// Checker for the NM ring node: mirrors its state, predicts results and compares them.
`timescale 1ns / 1ps

module direct_nm_ring_node_unit_checker
    import dnmrn_pkg::*;
#(
    parameter int NODE_SLOTS = NODE_SLOTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    dnmrn_in_if                    in_ch,
    dnmrn_out_if                   out_ch,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic       has_frame;
        logic [7:0] dest;
        logic [7:0] op;
        logic       last;
        logic       stable;
        logic       sleep;
        logic       presleep;
    } nm_result_t;

    nm_result_t expected_results[$];

    logic [7:0] own_addr, typ_limit, max_limit, min_sent, max_sent;

    logic [7:0] id_list [NODE_SLOTS];
    int         id_count;
    logic [7:0] pred_id, succ_id, hi_seen, lo_seen;
    logic       stable, sleep, alive_pend, typ_armed, max_armed, presleep;
    logic [7:0] typ_cnt, max_cnt;
    logic [7:0] tx_dest [$];
    logic [7:0] tx_op [$];

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic void queue_frame(input logic [7:0] d, input logic [7:0] o);
        if (tx_dest.size() < MAX_FRAMES)
        begin
            tx_dest.push_back(d);
            tx_op.push_back(o);
        end
    endfunction

    function automatic bit id_present(input logic [7:0] id);
        for (int i = 0; i < id_count; i++)
            if (id_list[i] == id)
                return 1;
        return 0;
    endfunction

    function automatic void add_id(input logic [7:0] id);
        int pos;
        if (id_present(id) || id_count >= NODE_SLOTS)
            return;
        pos = 0;
        while (pos < id_count && id_list[pos] < id)
            pos++;
        for (int j = id_count; j > pos; j--)
            id_list[j] = id_list[j - 1];
        id_list[pos] = id;
        id_count++;
    endfunction

    function automatic void restart_ring();
        stable     = 0;
        sleep      = 0;
        alive_pend = 1;
        succ_id    = max_sent;
        pred_id    = min_sent;
        hi_seen    = own_addr;
        lo_seen    = own_addr;
        queue_frame(own_addr, OPC_ALIVE);
        typ_armed  = 1;
        typ_cnt    = 0;
        add_id(own_addr);
    endfunction

    function automatic void typical_expired();
        typ_armed = 0;
        typ_cnt   = 0;
        if (!stable)
        begin
            if (id_count > 0)
            begin
                if (pred_id == min_sent)
                    pred_id = id_list[id_count - 1];
                if (succ_id == max_sent)
                    succ_id = id_list[0];
            end
            stable = 1;
            if (id_count > 0 && id_list[0] == own_addr)
                queue_frame(succ_id, OPC_RING);
        end
        queue_frame(pred_id, sleep ? (OPC_RING | OPC_SLEEP_IND) : OPC_RING);
        max_armed = 1;
        max_cnt   = 0;
    endfunction

    function automatic void predict_event(input logic [1:0] f, input logic [7:0] src,
                                          input logic [7:0] dst, input logic [7:0] op);
        int n;
        nm_result_t r;
        tx_dest.delete();
        tx_op.delete();
        if (f == FUNC_TICK)
        begin
            if (alive_pend)
                queue_frame(own_addr, OPC_ALIVE);
            else
            begin
                if (typ_armed)
                begin
                    typ_cnt++;
                    if (typ_cnt == typ_limit)
                        typical_expired();
                end
                if (max_armed)
                begin
                    max_cnt++;
                    if (max_cnt == max_limit)
                    begin
                        max_armed = 0;
                        max_cnt   = 0;
                        restart_ring();
                    end
                end
            end
        end
        else if (f == FUNC_MSG)
        begin
            alive_pend = 0;
            typ_armed  = 0;
            typ_cnt    = 0;
            max_armed  = 0;
            max_cnt    = 0;
            if ((op & MSGTYPE_MASK) == OPC_ALIVE)
            begin
                if (dst > hi_seen)
                    hi_seen = dst;
                if (dst < lo_seen)
                    lo_seen = dst;
                if (dst > pred_id && dst < own_addr)
                    pred_id = src;
                if (src > own_addr && src < succ_id)
                    succ_id = src;
                add_id(src);
                stable = 0;
            end
            else if ((op & MSGTYPE_MASK) == OPC_RING)
            begin
                // A ring message that skipped this node breaks the ring.
                if ((dst > own_addr && src < own_addr) || (dst < src && src < own_addr)
                    || (dst < src && dst > own_addr))
                    restart_ring();
                else if (dst == own_addr)
                begin
                    pred_id = src;
                    if ((op & OPC_SLEEP_IND) != 0)
                    begin
                        sleep    = 1;
                        presleep = 1;
                    end
                    typ_armed = 1;
                    typ_cnt   = 0;
                end
                else
                begin
                    max_armed = 1;
                    max_cnt   = 0;
                end
            end
        end
        else if (f == FUNC_START)
        begin
            presleep = 0;
            restart_ring();
        end
        n = (tx_dest.size() > 0) ? tx_dest.size() : 1;
        for (int k = 0; k < n; k++)
        begin
            r.has_frame = (k < tx_dest.size());
            r.dest      = r.has_frame ? tx_dest[k] : 8'h00;
            r.op        = r.has_frame ? tx_op[k] : 8'h00;
            r.last      = (k + 1 == n);
            r.stable    = stable;
            r.sleep     = sleep;
            r.presleep  = presleep;
            expected_results.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nm_result_t w;
        if (!rst_n)
        begin
            own_addr   = 8'd1;
            typ_limit  = 8'd10;
            max_limit  = 8'd26;
            min_sent   = 8'd0;
            max_sent   = 8'd255;
            for (int i = 0; i < NODE_SLOTS; i++)
                id_list[i] = 8'h00;
            id_count   = 0;
            pred_id    = 8'd0;
            succ_id    = 8'd255;
            hi_seen    = 8'd1;
            lo_seen    = 8'd1;
            stable     = 0;
            sleep      = 0;
            alive_pend = 1;
            typ_armed  = 0;
            typ_cnt    = 0;
            max_armed  = 0;
            max_cnt    = 0;
            presleep   = 0;
            expected_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OWN_ADDRESS:   own_addr  = cfg_data;
                    REG_TYPICAL_TICKS: typ_limit = cfg_data;
                    REG_MAX_TICKS:     max_limit = cfg_data;
                    REG_ID_MIN:        min_sent  = cfg_data;
                    REG_ID_MAX:        max_sent  = cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_event(in_ch.func, in_ch.src_id, in_ch.dest_id, in_ch.opcode);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result transfers", 8'd1, 8'd0);
                end
                else
                begin
                    w = expected_results.pop_front();
                    if (out_ch.has_frame !== w.has_frame)
                        report_mismatch("has_frame", out_ch.has_frame, w.has_frame);
                    if (out_ch.frame_dest !== w.dest)
                        report_mismatch("frame_dest", out_ch.frame_dest, w.dest);
                    if (out_ch.frame_opcode !== w.op)
                        report_mismatch("frame_opcode", out_ch.frame_opcode, w.op);
                    if (out_ch.last !== w.last)
                        report_mismatch("last", out_ch.last, w.last);
                    if (out_ch.ring_is_stable !== w.stable)
                        report_mismatch("ring_is_stable", out_ch.ring_is_stable, w.stable);
                    if (out_ch.sleep_indicated !== w.sleep)
                        report_mismatch("sleep_indicated", out_ch.sleep_indicated, w.sleep);
                    if (out_ch.prepare_sleep !== w.presleep)
                        report_mismatch("prepare_sleep", out_ch.prepare_sleep, w.presleep);
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

### sim/direct_nm_ring_node_unit_tb.sv
// Testbench top of the NM ring node: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module direct_nm_ring_node_unit_tb;
    import dnmrn_pkg::*;

    localparam int SLOTS       = NODE_SLOTS_DEF;
    // Cycles the block may still be busy after its last result (the chain walk).
    localparam int SETTLE      = SLOTS + 10;
    // Cycles without any transfer before the run is declared hung.
    localparam int HANG_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 50;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending;
    int                     send_idle;
    int                     recv_stall;
    int                     quiet_cycles;
    logic [7:0]             own_now;

    dnmrn_in_if  in_ch ();
    dnmrn_out_if out_ch ();

    direct_nm_ring_node_unit #(.NODE_SLOTS(SLOTS)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    direct_nm_ring_node_unit_checker #(.NODE_SLOTS(SLOTS)) checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // The receiver decides at each falling edge whether it takes a result in the
    // coming cycle; the stall rate belongs to the current phase.
    initial
    begin
        out_ch.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ch.ready = ($urandom_range(99) >= recv_stall);
    end

    // Any transfer on either channel counts as progress. A long stretch with none
    // means the block has hung.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("direct_nm_ring_node_unit_tb failed");
            $finish;
        end
    end

    // Offers one event and holds it until the transfer happens. Valid is left high
    // afterwards so that back-to-back events keep it up without a glitch; the next
    // gap or the next quiet period lowers it.
    task automatic send_event(input logic [1:0] f, input logic [7:0] src,
                              input logic [7:0] dst, input logic [7:0] op);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.func    = f;
        in_ch.src_id  = src;
        in_ch.dest_id = dst;
        in_ch.opcode  = op;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops the sender and waits until every predicted result has arrived, then lets
    // the block finish any list insert still in flight.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Writes the full register set; only ever called while the block is idle.
    task automatic load_setting(input logic [7:0] own, input logic [7:0] typ,
                                input logic [7:0] mx, input logic [7:0] lo,
                                input logic [7:0] hi);
        write_reg(REG_OWN_ADDRESS, own);
        write_reg(REG_TYPICAL_TICKS, typ);
        write_reg(REG_MAX_TICKS, mx);
        write_reg(REG_ID_MIN, lo);
        write_reg(REG_ID_MAX, hi);
        own_now = own;
    endtask

    // One random event. Most are well-formed ticks, alive and ring messages with
    // random content so the ring actually forms and times out; the rest are starts,
    // the unused function code and raw noise. alive_pct steers how hard the node
    // list is filled.
    task automatic random_event(input int alive_pct);
        int         pick;
        logic [7:0] upper;
        logic [7:0] dst;
        pick  = $urandom_range(99);
        upper = 8'($urandom_range(255));
        if (pick < 40)
            send_event(FUNC_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        else if (pick < 40 + alive_pct)
            send_event(FUNC_MSG, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       (upper & ~MSGTYPE_MASK) | OPC_ALIVE);
        else if (pick < 80)
        begin
            dst = ($urandom_range(1) == 1) ? own_now : 8'($urandom_range(255));
            send_event(FUNC_MSG, 8'($urandom_range(255)), dst,
                       (upper & ~MSGTYPE_MASK) | OPC_RING);
        end
        else if (pick < 86)
            send_event(FUNC_START, 8'($urandom_range(255)), 8'($urandom_range(255)), upper);
        else if (pick < 90)
            send_event(FUNC_SPARE, 8'($urandom_range(255)), 8'($urandom_range(255)), upper);
        else
            send_event(2'($urandom_range(3)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), upper);
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input int alive_pct,
                                input bit hold_off);
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // With hold_off set, the sender holds back once in the run until every result is home.
            if (hold_off && i == RANDOM_ITEMS / 2)
            begin
                in_ch.valid = 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            random_event(alive_pct);
        end
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FUNC_TICK;
        in_ch.src_id  = 8'h00;
        in_ch.dest_id = 8'h00;
        in_ch.opcode  = 8'h00;
        send_idle     = 0;
        recv_stall    = 0;
        quiet_cycles  = 0;
        own_now       = 8'd1;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        drain();

        // Directed part with short timers so that each timeout is reached quickly.
        load_setting(8'd1, 8'd2, 8'd3, 8'd0, 8'd255);
        send_event(FUNC_TICK, 8'h00, 8'h00, 8'h00);                  // alive still pending
        send_event(FUNC_START, 8'hff, 8'hff, 8'hff);
        send_event(FUNC_TICK, 8'hff, 8'hff, 8'hff);
        send_event(FUNC_MSG, 8'd5, 8'd5, OPC_ALIVE);
        send_event(FUNC_MSG, 8'd0, 8'd0, OPC_ALIVE);
        send_event(FUNC_MSG, 8'd255, 8'd255, 8'hf9);                 // alive, upper bits set
        send_event(FUNC_TICK, 8'h00, 8'h00, 8'h00);
        send_event(FUNC_TICK, 8'h00, 8'h00, 8'h00);                  // no timer armed
        send_event(FUNC_MSG, 8'd0, 8'd1, OPC_RING | OPC_SLEEP_IND);  // ring to us, sleep
        send_event(FUNC_TICK, 8'h00, 8'h00, 8'h00);
        send_event(FUNC_TICK, 8'h00, 8'h00, 8'h00);
        send_event(FUNC_MSG, 8'd2, 8'd3, OPC_RING);                  // ring past us: max armed
        send_event(FUNC_TICK, 8'h00, 8'h00, 8'h00);
        send_event(FUNC_TICK, 8'h00, 8'h00, 8'h00);
        send_event(FUNC_TICK, 8'h00, 8'h00, 8'h00);                  // max timeout
        send_event(FUNC_MSG, 8'd0, 8'd5, OPC_RING | OPC_SLEEP_ACK);  // skipped ring
        send_event(FUNC_MSG, 8'd7, 8'd1, OPC_LIMP_HOME);
        send_event(FUNC_MSG, 8'hff, 8'hff, 8'hff);                   // unknown message type
        send_event(FUNC_MSG, 8'h00, 8'h00, 8'h00);
        send_event(FUNC_SPARE, 8'hff, 8'hff, 8'hff);                 // unused function code
        send_event(FUNC_START, 8'h00, 8'h00, 8'h00);
        send_event(FUNC_TICK, 8'h00, 8'h00, 8'h00);
        drain();

        random_phase(0, 0, 20, 1'b0);
        load_setting(8'd255, 8'd1, 8'd2, 8'd255, 8'd0);
        random_phase(83, 0, 20, 1'b1);
        load_setting(8'd0, 8'd255, 8'd255, 8'd0, 8'd255);
        random_phase(0, 83, 20, 1'b0);
        load_setting(8'd128, 8'd3, 8'd6, 8'h7f, 8'h80);
        random_phase(17, 17, 20, 1'b0);
        // A last phase heavy in alive messages pushes the node list toward full.
        load_setting(8'd1, 8'd4, 8'd9, 8'd0, 8'd255);
        random_phase(0, 0, 35, 1'b0);

        if (fail_count == 0)
            $display("direct_nm_ring_node_unit_tb passed");
        else
            $display("direct_nm_ring_node_unit_tb failed");
        $finish;
    end

endmodule

### files.f
hdl/dnmrn_pkg.sv
hdl/dnmrn_if.sv
hdl/dnmrn_cell.sv
hdl/direct_nm_ring_node_unit.sv
sim/direct_nm_ring_node_unit_checker.sv
sim/direct_nm_ring_node_unit_tb.sv
